// ===== sv/cbcr_pkg.sv =====
// shared types and constants for the circle versus box collision resolver
package cbcr_pkg;

    localparam int FRAC_BITS = 16;

    localparam int POS_W    = 32;
    localparam int RADIUS_W = 19;
    localparam int EYE_W    = 21;
    localparam int HEAD_W   = 19;
    localparam int CFG_W    = 21;
    localparam int CFG_IDX_W = 2;

    localparam int OPND_W = 40;
    localparam int ROOT_W = 20;

    localparam logic [RADIUS_W-1:0] RADIUS_RST = RADIUS_W'(13107);
    localparam logic [EYE_W-1:0]    EYE_RST    = EYE_W'(65536);
    localparam logic [HEAD_W-1:0]   HEAD_RST   = HEAD_W'(6554);

    localparam logic [ROOT_W-1:0] ZERO_DIST =
        ROOT_W'((64'd1 << FRAC_BITS) / 64'd1000000);

    localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EYE    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HEAD   = 2'd3;

    typedef enum logic {
        MODE_DIV  = 1'b0,
        MODE_SQRT = 1'b1
    } unit_mode_t;

    typedef struct packed {
        logic       start;
        unit_mode_t mode;
    } unit_req_t;

    typedef struct packed {
        logic                enable;
        logic [RADIUS_W-1:0] radius;
        logic [EYE_W-1:0]    eye;
        logic [HEAD_W-1:0]   head;
    } cfg_t;

endpackage

// ===== sv/circle_box_collision_resolver_unit.sv =====
// top level: player cylinder against axis-aligned boxes, Q16.16 fixed point
// A load item, and a box item with collision off, goes from idle straight to the output
// stage. A box item that is not solid or misses vertically leaves at S_VERT, one whose
// offset reaches the radius at S_FAR and one whose squared distance reaches the radius
// squared at S_CMP; one that needs a push runs a square root and, unless the distance is
// zero, two divisions on the one shared bit-serial root/divide unit. The input is ready only
// while no item is in work; a finished result waits in its own output register.
module circle_box_collision_resolver_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [cbcr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cbcr_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_command,
    input  logic signed [31:0]             s_load_x,
    input  logic signed [31:0]             s_load_y,
    input  logic signed [31:0]             s_load_z,
    input  logic signed [31:0]             s_box_min_x,
    input  logic signed [31:0]             s_box_min_y,
    input  logic signed [31:0]             s_box_min_z,
    input  logic signed [31:0]             s_box_max_x,
    input  logic signed [31:0]             s_box_max_y,
    input  logic signed [31:0]             s_box_max_z,
    input  logic                           s_solid,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic signed [31:0]             m_out_x,
    output logic signed [31:0]             m_out_y,
    output logic signed [31:0]             m_out_z,
    output logic                           m_pushed
);

    typedef enum logic [3:0] {
        S_IDLE, S_VERT, S_CLAMP, S_FAR, S_RSQ, S_SQX, S_SQZ, S_CMP,
        S_ROOT, S_MULX, S_DIVX, S_MULZ, S_DIVZ, S_FACE, S_OUT
    } state_t;

    localparam int W  = cbcr_pkg::POS_W;
    localparam int RW = cbcr_pkg::RADIUS_W;
    localparam int OW = cbcr_pkg::OPND_W;
    localparam int QW = cbcr_pkg::ROOT_W;

    function automatic logic signed [W-1:0] sat32(input logic signed [OW+1:0] v);
        if (v > $signed({{(OW+2-W){1'b0}}, 1'b0, {(W-1){1'b1}}}))
            return {1'b0, {(W-1){1'b1}}};
        else if (v < $signed({{(OW+2-W){1'b1}}, 1'b1, {(W-1){1'b0}}}))
            return {1'b1, {(W-1){1'b0}}};
        else
            return v[W-1:0];
    endfunction

    cbcr_pkg::cfg_t      cfg;
    cbcr_pkg::unit_req_t ureq;
    logic [OW-1:0]       u_operand;
    logic                u_done;
    logic [OW-1:0]       u_result;

    state_t                 state_reg;
    logic signed [W-1:0]    pos_x_reg, pos_y_reg, pos_z_reg;
    logic signed [W-1:0]    old_x_reg, old_y_reg, old_z_reg;
    logic signed [W-1:0]    mnx_reg, mny_reg, mnz_reg, mxx_reg, mxy_reg, mxz_reg;
    logic                   solid_reg;
    logic signed [W:0]      dx_reg, dz_reg;
    logic signed [W:0]      pxn_reg, pxp_reg, pzn_reg, pzp_reg;
    logic [RW-1:0]          adx_reg, adz_reg;
    logic                   nx_reg, nz_reg;
    logic [OW-1:0]          dsq_reg, rsq_reg;
    logic [QW-1:0]          root_reg;
    logic [RW-1:0]          pen_reg;
    logic                   m_valid_reg, m_pushed_reg;
    logic signed [W-1:0]    m_x_reg, m_y_reg, m_z_reg;

    logic [QW-1:0]          mul_a, mul_b;
    logic [OW-1:0]          mul_p;
    logic signed [W+1:0]    feet, head;
    logic signed [W-1:0]    cx, cz;
    logic signed [W:0]      dx_next, dz_next;
    logic [W:0]             adx, adz;
    logic signed [OW+1:0]   qx_signed, qz_signed, face_sum;
    logic signed [OW+1:0]   newx_sum, newz_sum;

    cbcr_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    cbcr_shared_unit u_unit (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (ureq),
        .operand (u_operand),
        .divisor (root_reg),
        .done    (u_done),
        .result  (u_result)
    );

    always_comb begin
        unique case (state_reg)
            S_RSQ:   begin mul_a = QW'(cfg.radius); mul_b = QW'(cfg.radius); end
            S_SQX:   begin mul_a = QW'(adx_reg);    mul_b = QW'(adx_reg);    end
            S_SQZ:   begin mul_a = QW'(adz_reg);    mul_b = QW'(adz_reg);    end
            S_MULX:  begin mul_a = QW'(adx_reg);    mul_b = QW'(pen_reg);    end
            S_MULZ:  begin mul_a = QW'(adz_reg);    mul_b = QW'(pen_reg);    end
            default: begin mul_a = '0;              mul_b = '0;              end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    always_comb begin
        ureq.start = 1'b0;
        ureq.mode  = cbcr_pkg::MODE_DIV;
        u_operand  = mul_p;
        if (state_reg == S_CMP && dsq_reg < rsq_reg) begin
            ureq.start = 1'b1;
            ureq.mode  = cbcr_pkg::MODE_SQRT;
            u_operand  = dsq_reg;
        end else if (state_reg == S_MULX || state_reg == S_MULZ) begin
            ureq.start = 1'b1;
        end
    end

    always_comb begin
        feet = (W+2)'(pos_y_reg) - $signed({1'b0, (W+1)'(cfg.eye)});
        head = (W+2)'(pos_y_reg) + $signed({1'b0, (W+1)'(cfg.head)});
        if (pos_x_reg < mnx_reg)      cx = mnx_reg;
        else if (pos_x_reg > mxx_reg) cx = mxx_reg;
        else                          cx = pos_x_reg;
        if (pos_z_reg < mnz_reg)      cz = mnz_reg;
        else if (pos_z_reg > mxz_reg) cz = mxz_reg;
        else                          cz = pos_z_reg;
        dx_next = (W+1)'(pos_x_reg) - (W+1)'(cx);
        dz_next = (W+1)'(pos_z_reg) - (W+1)'(cz);
        adx = dx_reg[W] ? W'(1'b0) - dx_reg : dx_reg;
        adz = dz_reg[W] ? W'(1'b0) - dz_reg : dz_reg;
        qx_signed = nx_reg ? -$signed({2'b00, u_result}) : $signed({2'b00, u_result});
        qz_signed = nz_reg ? -$signed({2'b00, u_result}) : $signed({2'b00, u_result});
        newx_sum  = (OW+2)'(pos_x_reg) + qx_signed;
        newz_sum  = (OW+2)'(pos_z_reg) + qz_signed;
        face_sum  = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            pos_x_reg   <= '0;
            pos_y_reg   <= '0;
            pos_z_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && state_reg != S_OUT)
                m_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        old_x_reg <= s_command ? pos_x_reg : s_load_x;
                        old_y_reg <= s_command ? pos_y_reg : s_load_y;
                        old_z_reg <= s_command ? pos_z_reg : s_load_z;
                        mnx_reg   <= s_box_min_x;
                        mny_reg   <= s_box_min_y;
                        mnz_reg   <= s_box_min_z;
                        mxx_reg   <= s_box_max_x;
                        mxy_reg   <= s_box_max_y;
                        mxz_reg   <= s_box_max_z;
                        solid_reg <= s_solid;
                        if (!s_command) begin
                            pos_x_reg <= s_load_x;
                            pos_z_reg <= s_load_z;
                            if (cfg.enable && s_load_y < $signed(W'(cfg.eye)))
                                pos_y_reg <= W'(cfg.eye);
                            else
                                pos_y_reg <= s_load_y;
                            state_reg <= S_OUT;
                        end else if (!cfg.enable) begin
                            state_reg <= S_OUT;
                        end else begin
                            state_reg <= S_VERT;
                        end
                    end
                end
                S_VERT: begin
                    if (!solid_reg || feet >= (W+2)'(mxy_reg) || head <= (W+2)'(mny_reg))
                        state_reg <= S_OUT;
                    else
                        state_reg <= S_CLAMP;
                end
                S_CLAMP: begin
                    dx_reg    <= dx_next;
                    dz_reg    <= dz_next;
                    pxn_reg   <= (W+1)'(pos_x_reg) - (W+1)'(mnx_reg);
                    pxp_reg   <= (W+1)'(mxx_reg) - (W+1)'(pos_x_reg);
                    pzn_reg   <= (W+1)'(pos_z_reg) - (W+1)'(mnz_reg);
                    pzp_reg   <= (W+1)'(mxz_reg) - (W+1)'(pos_z_reg);
                    state_reg <= S_FAR;
                end
                S_FAR: begin
                    adx_reg <= adx[RW-1:0];
                    adz_reg <= adz[RW-1:0];
                    nx_reg  <= dx_reg[W];
                    nz_reg  <= dz_reg[W];
                    if (adx >= (W+1)'(cfg.radius) || adz >= (W+1)'(cfg.radius))
                        state_reg <= S_OUT;
                    else
                        state_reg <= S_RSQ;
                end
                S_RSQ: begin
                    rsq_reg   <= mul_p;
                    state_reg <= S_SQX;
                end
                S_SQX: begin
                    dsq_reg   <= mul_p;
                    state_reg <= S_SQZ;
                end
                S_SQZ: begin
                    dsq_reg   <= dsq_reg + mul_p;
                    state_reg <= S_CMP;
                end
                S_CMP: begin
                    state_reg <= (dsq_reg < rsq_reg) ? S_ROOT : S_OUT;
                end
                S_ROOT: begin
                    if (u_done) begin
                        root_reg  <= u_result[QW-1:0];
                        pen_reg   <= cfg.radius - u_result[RW-1:0];
                        state_reg <= (u_result[QW-1:0] <= cbcr_pkg::ZERO_DIST) ? S_FACE : S_MULX;
                    end
                end
                S_MULX: state_reg <= S_DIVX;
                S_DIVX: begin
                    if (u_done) begin
                        pos_x_reg <= sat32(newx_sum);
                        state_reg <= S_MULZ;
                    end
                end
                S_MULZ: state_reg <= S_DIVZ;
                S_DIVZ: begin
                    if (u_done) begin
                        pos_z_reg <= sat32(newz_sum);
                        state_reg <= S_OUT;
                    end
                end
                S_FACE: begin
                    if (pxn_reg <= pxp_reg && pxn_reg <= pzn_reg && pxn_reg <= pzp_reg)
                        pos_x_reg <= sat32((OW+2)'(mnx_reg) - (OW+2)'(cfg.radius) + face_sum);
                    else if (pxp_reg <= pzn_reg && pxp_reg <= pzp_reg)
                        pos_x_reg <= sat32((OW+2)'(mxx_reg) + (OW+2)'(cfg.radius));
                    else if (pzn_reg <= pzp_reg)
                        pos_z_reg <= sat32((OW+2)'(mnz_reg) - (OW+2)'(cfg.radius));
                    else
                        pos_z_reg <= sat32((OW+2)'(mxz_reg) + (OW+2)'(cfg.radius));
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg  <= 1'b1;
                        m_x_reg      <= pos_x_reg;
                        m_y_reg      <= pos_y_reg;
                        m_z_reg      <= pos_z_reg;
                        m_pushed_reg <= (pos_x_reg != old_x_reg) || (pos_y_reg != old_y_reg)
                                        || (pos_z_reg != old_z_reg);
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_out_x  = m_x_reg;
    assign m_out_y  = m_y_reg;
    assign m_out_z  = m_z_reg;
    assign m_pushed = m_pushed_reg;

    // the shared unit only finishes while the sequencer waits on it
    assert property (@(posedge aclk) disable iff (!aresetn)
        u_done |-> (state_reg == S_ROOT || state_reg == S_DIVX || state_reg == S_DIVZ))
        else $error("shared unit finished outside a wait state");

    // box items with collision off go straight to the output stage
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_command && !cfg.enable) |=> (state_reg == S_OUT))
        else $error("disabled box item did not bypass");

    // a push never starts unless the squared distance is inside the radius
    assert property (@(posedge aclk) disable iff (!aresetn)
        (ureq.start && ureq.mode == cbcr_pkg::MODE_SQRT) |-> (dsq_reg < rsq_reg))
        else $error("root started outside the radius");

endmodule

// ===== sv/cbcr_cfg_regs.sv =====
// configuration registers
module cbcr_cfg_regs (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [cbcr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cbcr_pkg::CFG_W-1:0]     cfg_wdata,
    output cbcr_pkg::cfg_t                 cfg
);

    cbcr_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.enable <= 1'b1;
            cfg_reg.radius <= cbcr_pkg::RADIUS_RST;
            cfg_reg.eye    <= cbcr_pkg::EYE_RST;
            cfg_reg.head   <= cbcr_pkg::HEAD_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                cbcr_pkg::REG_ENABLE: cfg_reg.enable <= cfg_wdata[0];
                cbcr_pkg::REG_RADIUS: cfg_reg.radius <= cfg_wdata[cbcr_pkg::RADIUS_W-1:0];
                cbcr_pkg::REG_EYE:    cfg_reg.eye    <= cfg_wdata[cbcr_pkg::EYE_W-1:0];
                cbcr_pkg::REG_HEAD:   cfg_reg.head   <= cfg_wdata[cbcr_pkg::HEAD_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== sv/cbcr_shared_unit.sv =====
// shared restoring unit: one bit of quotient or root per cycle
module cbcr_shared_unit (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  cbcr_pkg::unit_req_t         req,
    input  logic [cbcr_pkg::OPND_W-1:0] operand,
    input  logic [cbcr_pkg::ROOT_W-1:0] divisor,
    output logic                        done,
    output logic [cbcr_pkg::OPND_W-1:0] result
);

    localparam int REM_W = 24;
    localparam int CNT_W = 6;
    localparam logic [CNT_W-1:0] SQRT_STEPS = CNT_W'(cbcr_pkg::OPND_W / 2 - 1);
    localparam logic [CNT_W-1:0] DIV_STEPS  = CNT_W'(cbcr_pkg::OPND_W - 1);

    logic                         busy_reg;
    logic                         done_reg;
    cbcr_pkg::unit_mode_t         mode_reg;
    logic [cbcr_pkg::OPND_W-1:0]  acc_reg, acc_next;
    logic [REM_W-1:0]             rem_reg, rem_next;
    logic [cbcr_pkg::OPND_W-1:0]  res_reg;
    logic [cbcr_pkg::ROOT_W-1:0]  div_reg;
    logic [CNT_W-1:0]             cnt_reg;
    logic [REM_W-1:0]             rem_sh, trial;
    logic [REM_W:0]               diff;
    logic                         ge;

    always_comb begin
        if (mode_reg == cbcr_pkg::MODE_SQRT) begin
            rem_sh   = {rem_reg[REM_W-3:0], acc_reg[cbcr_pkg::OPND_W-1 -: 2]};
            trial    = {2'b00, res_reg[cbcr_pkg::ROOT_W-1:0], 2'b01};
            acc_next = {acc_reg[cbcr_pkg::OPND_W-3:0], 2'b00};
        end else begin
            rem_sh   = {rem_reg[REM_W-2:0], acc_reg[cbcr_pkg::OPND_W-1]};
            trial    = {4'b0000, div_reg};
            acc_next = {acc_reg[cbcr_pkg::OPND_W-2:0], 1'b0};
        end
        diff     = {1'b0, rem_sh} - {1'b0, trial};
        ge       = !diff[REM_W];
        rem_next = ge ? diff[REM_W-1:0] : rem_sh;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                mode_reg <= req.mode;
                acc_reg  <= operand;
                rem_reg  <= '0;
                res_reg  <= '0;
                div_reg  <= divisor;
                cnt_reg  <= (req.mode == cbcr_pkg::MODE_SQRT) ? SQRT_STEPS : DIV_STEPS;
            end else if (busy_reg) begin
                acc_reg <= acc_next;
                rem_reg <= rem_next;
                res_reg <= {res_reg[cbcr_pkg::OPND_W-2:0], ge};
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

// ===== dv/tb_top.sv =====
// testbench for the circle versus box collision resolver: directed table, random boxes, checker
`timescale 1ns / 1ps

module tb_top;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_BOX  = 1'b1;
    localparam longint S32_MAX = 64'sd2147483647;
    localparam longint S32_MIN = -64'sd2147483648;

    typedef struct {
        logic               cmd;
        logic signed [31:0] ld [3];
        logic signed [31:0] mn [3];
        logic signed [31:0] mx [3];
        logic               solid;
    } box_item_t;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               pushed;
    } pos_beat_t;

    typedef struct {
        box_item_t it;
        bit        typed;
        pos_beat_t want;
    } table_row_t;

    logic aclk;
    logic aresetn;
    logic cfg_wr_en;
    logic [cbcr_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [cbcr_pkg::CFG_W-1:0] cfg_wdata;
    logic s_valid, s_ready, s_command, s_solid;
    logic signed [31:0] s_load_x, s_load_y, s_load_z;
    logic signed [31:0] s_box_min_x, s_box_min_y, s_box_min_z;
    logic signed [31:0] s_box_max_x, s_box_max_y, s_box_max_z;
    logic m_valid, m_ready, m_pushed;
    logic signed [31:0] m_out_x, m_out_y, m_out_z;

    circle_box_collision_resolver_unit u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_command(s_command),
        .s_load_x(s_load_x), .s_load_y(s_load_y), .s_load_z(s_load_z),
        .s_box_min_x(s_box_min_x), .s_box_min_y(s_box_min_y), .s_box_min_z(s_box_min_z),
        .s_box_max_x(s_box_max_x), .s_box_max_y(s_box_max_y), .s_box_max_z(s_box_max_z),
        .s_solid(s_solid),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_out_x(m_out_x), .m_out_y(m_out_y), .m_out_z(m_out_z), .m_pushed(m_pushed)
    );

    // predictor copy of position and registers
    longint pl_x, pl_y, pl_z;
    bit     pl_enable;
    longint pl_radius, pl_eye, pl_head;

    pos_beat_t want_q [$];
    int  mismatches;
    int  beats_checked;
    int  pushes_seen;
    int  idle_pct;
    int  stall_pct;
    int  hold_left;

    function automatic longint sat32(longint v);
        if (v > S32_MAX) return S32_MAX;
        if (v < S32_MIN) return S32_MIN;
        return v;
    endfunction

    function automatic longint clamp_to(longint v, longint lo, longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic longint floor_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return longint'(res);
    endfunction

    function automatic longint push_share(longint d, longint pen, longint dlen);
        longint q;
        q = ((d < 0 ? -d : d) * pen) / dlen;
        return d < 0 ? -q : q;
    endfunction

    function automatic pos_beat_t resolve_item(box_item_t it);
        longint ox, oy, oz, mnx, mny, mnz, mxx, mxy, mxz, dx, dz, dsq, dlen, pen;
        longint pxn, pxp, pzn, pzp, m;
        pos_beat_t r;
        ox = pl_x; oy = pl_y; oz = pl_z;
        if (it.cmd == CMD_LOAD) begin
            pl_x = it.ld[0]; pl_y = it.ld[1]; pl_z = it.ld[2];
            ox = pl_x; oy = pl_y; oz = pl_z;
            if (pl_enable && pl_y < pl_eye) pl_y = sat32(pl_eye);
        end else if (pl_enable && it.solid) begin
            mnx = it.mn[0]; mny = it.mn[1]; mnz = it.mn[2];
            mxx = it.mx[0]; mxy = it.mx[1]; mxz = it.mx[2];
            if (!(pl_y - pl_eye >= mxy || pl_y + pl_head <= mny)) begin
                dx = pl_x - clamp_to(pl_x, mnx, mxx);
                dz = pl_z - clamp_to(pl_z, mnz, mxz);
                dsq = dx * dx + dz * dz;
                if (!(dx >= pl_radius || -dx >= pl_radius || dz >= pl_radius ||
                      -dz >= pl_radius) && dsq < pl_radius * pl_radius) begin
                    dlen = floor_sqrt(dsq);
                    if (dlen > longint'(cbcr_pkg::ZERO_DIST)) begin
                        pen = pl_radius - dlen;
                        pl_x = sat32(pl_x + push_share(dx, pen, dlen));
                        pl_z = sat32(pl_z + push_share(dz, pen, dlen));
                    end else begin
                        pxn = pl_x - mnx; pxp = mxx - pl_x;
                        pzn = pl_z - mnz; pzp = mxz - pl_z;
                        m = pxn;
                        if (pxp < m) m = pxp;
                        if (pzn < m) m = pzn;
                        if (pzp < m) m = pzp;
                        if (m == pxn)      pl_x = sat32(mnx - pl_radius);
                        else if (m == pxp) pl_x = sat32(mxx + pl_radius);
                        else if (m == pzn) pl_z = sat32(mnz - pl_radius);
                        else               pl_z = sat32(mxz + pl_radius);
                    end
                end
            end
        end
        r.x = pl_x[31:0]; r.y = pl_y[31:0]; r.z = pl_z[31:0];
        r.pushed = (pl_x != ox) || (pl_y != oy) || (pl_z != oz);
        return r;
    endfunction

    function automatic box_item_t mk_load(longint x, longint y, longint z);
        box_item_t it;
        it.cmd = CMD_LOAD;
        it.ld[0] = x[31:0]; it.ld[1] = y[31:0]; it.ld[2] = z[31:0];
        for (int a = 0; a < 3; a++) begin
            it.mn[a] = $urandom; it.mx[a] = $urandom;
        end
        it.solid = $urandom_range(1);
        return it;
    endfunction

    function automatic box_item_t mk_box(longint x0, longint y0, longint z0,
                                         longint x1, longint y1, longint z1, bit solid);
        box_item_t it;
        it.cmd = CMD_BOX;
        for (int a = 0; a < 3; a++) it.ld[a] = $urandom;
        it.mn[0] = x0[31:0]; it.mn[1] = y0[31:0]; it.mn[2] = z0[31:0];
        it.mx[0] = x1[31:0]; it.mx[1] = y1[31:0]; it.mx[2] = z1[31:0];
        it.solid = solid;
        return it;
    endfunction

    function automatic pos_beat_t mk_pos(longint x, longint y, longint z, bit p);
        pos_beat_t r;
        r.x = x[31:0]; r.y = y[31:0]; r.z = z[31:0]; r.pushed = p;
        return r;
    endfunction

    // random item, mostly boxes placed around the current position
    function automatic box_item_t rand_item();
        longint rr, off, w, c, lo, hi;
        longint p [3];
        box_item_t it;
        int pick;
        pick = $urandom_range(99);
        rr = (pl_radius == 0) ? 4096 : pl_radius;
        if (pick < 4) begin
            it = mk_box(0, 0, 0, 0, 0, 0, 1);
            for (int a = 0; a < 3; a++) begin
                it.mn[a] = $urandom; it.mx[a] = $urandom;
            end
            it.solid = $urandom_range(1);
            if ($urandom_range(1)) it = mk_load($signed($urandom), $signed($urandom),
                                               $signed($urandom));
            return it;
        end
        if (pick < 16) begin
            return mk_load(longint'($urandom_range(8 * rr)) - 4 * rr,
                           longint'($urandom_range(4 * 65536)) - 65536,
                           longint'($urandom_range(8 * rr)) - 4 * rr);
        end
        p[0] = pl_x; p[1] = pl_y; p[2] = pl_z;
        it = mk_box(0, 0, 0, 0, 0, 0, $urandom_range(9) != 0);
        for (int a = 0; a < 3; a += 2) begin
            if ($urandom_range(7) == 0) off = 0;
            else off = longint'($urandom_range(4 * rr)) - 2 * rr;
            w = $urandom_range(2 * rr);
            c = p[a] + off;
            lo = sat32(c - w); hi = sat32(c + w);
            if ($urandom_range(19) == 0) begin
                it.mn[a] = hi[31:0]; it.mx[a] = lo[31:0];
            end else begin
                it.mn[a] = lo[31:0]; it.mx[a] = hi[31:0];
            end
        end
        lo = sat32(p[1] - pl_eye - longint'($urandom_range(65536)));
        hi = sat32(p[1] + longint'($urandom_range(65536)));
        if ($urandom_range(9) == 0) lo = sat32(p[1] + pl_head + $urandom_range(1000) - 500);
        if ($urandom_range(9) == 0) hi = sat32(p[1] - pl_eye + $urandom_range(1000) - 500);
        it.mn[1] = lo[31:0]; it.mx[1] = hi[31:0];
        return it;
    endfunction

    task automatic send_item(box_item_t it, bit typed, pos_beat_t want);
        pos_beat_t r;
        if ($urandom_range(99) < idle_pct) begin
            @(negedge aclk);
            s_valid = 1'b0;
            while ($urandom_range(99) < idle_pct) @(negedge aclk);
        end
        @(negedge aclk);
        s_command = it.cmd; s_solid = it.solid;
        s_load_x = it.ld[0]; s_load_y = it.ld[1]; s_load_z = it.ld[2];
        s_box_min_x = it.mn[0]; s_box_min_y = it.mn[1]; s_box_min_z = it.mn[2];
        s_box_max_x = it.mx[0]; s_box_max_y = it.mx[1]; s_box_max_z = it.mx[2];
        s_valid = 1'b1;
        do @(posedge aclk); while (!s_ready);
        r = resolve_item(it);
        want_q.push_back(typed ? want : r);
    endtask

    task automatic drain_and_settle();
        @(negedge aclk);
        s_valid = 1'b0;
        wait (want_q.size() == 0);
        repeat (150) @(negedge aclk);
    endtask

    task automatic write_reg(logic [cbcr_pkg::CFG_IDX_W-1:0] idx, longint v);
        @(negedge aclk);
        cfg_wr_en = 1'b1; cfg_index = idx; cfg_wdata = v[cbcr_pkg::CFG_W-1:0];
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        case (idx)
            cbcr_pkg::REG_ENABLE: pl_enable = v[0];
            cbcr_pkg::REG_RADIUS: pl_radius = v & 64'h7FFFF;
            cbcr_pkg::REG_EYE:    pl_eye    = v & 64'h1FFFFF;
            default:              pl_head   = v & 64'h7FFFF;
        endcase
    endtask

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // result side ready, with an optional long hold-off
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                m_ready = 1'b0;
            end else begin
                m_ready = $urandom_range(99) >= stall_pct;
            end
        end
    end

    always @(posedge aclk) begin
        pos_beat_t w;
        if (aresetn && m_valid && m_ready) begin
            if (want_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected beat x=%0d y=%0d z=%0d",
                                               m_out_x, m_out_y, m_out_z);
            end else begin
                w = want_q.pop_front();
                beats_checked++;
                if (m_pushed) pushes_seen++;
                if (m_out_x !== w.x || m_out_y !== w.y || m_out_z !== w.z ||
                    m_pushed !== w.pushed) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch beat %0d: exp %0d %0d %0d p%0b got %0d %0d %0d p%0b",
                                 beats_checked, w.x, w.y, w.z, w.pushed,
                                 m_out_x, m_out_y, m_out_z, m_pushed);
                end
            end
        end
    end

    initial begin
        #20ms;
        $display("timeout with %0d beats outstanding", want_q.size());
        $display("circle_box_collision_resolver_unit test failed");
        $finish;
    end

    initial begin
        table_row_t rows [$];
        longint cfgs [5][4];
        pos_beat_t none;
        aresetn = 1'b0; cfg_wr_en = 1'b0; cfg_index = '0; cfg_wdata = '0;
        s_valid = 1'b0; s_command = CMD_LOAD; s_solid = 1'b0;
        s_load_x = '0; s_load_y = '0; s_load_z = '0;
        s_box_min_x = '0; s_box_min_y = '0; s_box_min_z = '0;
        s_box_max_x = '0; s_box_max_y = '0; s_box_max_z = '0;
        mismatches = 0; beats_checked = 0; pushes_seen = 0;
        idle_pct = 0; stall_pct = 0; hold_left = 0;
        pl_x = 0; pl_y = 0; pl_z = 0;
        pl_enable = 1'b1; pl_radius = 13107; pl_eye = 65536; pl_head = 6554;
        none = mk_pos(0, 0, 0, 0);
        repeat (8) @(negedge aclk);
        aresetn = 1'b1;

        // directed table, reset register values
        rows.push_back('{mk_load(0, 0, 0), 1, mk_pos(0, 65536, 0, 1)});
        rows.push_back('{mk_load(S32_MAX, S32_MAX, S32_MAX), 1,
                         mk_pos(S32_MAX, S32_MAX, S32_MAX, 0)});
        rows.push_back('{mk_load(S32_MIN, S32_MIN, S32_MIN), 1,
                         mk_pos(S32_MIN, 65536, S32_MIN, 1)});
        rows.push_back('{mk_box(S32_MIN, S32_MIN, S32_MIN, S32_MAX, S32_MAX, S32_MAX, 0), 1,
                         mk_pos(S32_MIN, 65536, S32_MIN, 0)});
        rows.push_back('{mk_load(0, 65536, 0), 1, mk_pos(0, 65536, 0, 0)});
        rows.push_back('{mk_box(10000, 0, -100, 100000, 131072, 100, 1), 0, none});
        rows.push_back('{mk_load(0, 65536, 0), 0, none});
        rows.push_back('{mk_box(-20000, 200000, -100, 20000, 300000, 100, 1), 0, none});
        rows.push_back('{mk_box(-20000, -300000, -100, 20000, 0, 100, 1), 0, none});
        rows.push_back('{mk_box(-100, 0, -300, 200, 131072, 300, 1), 0, none});
        rows.push_back('{mk_load(0, 65536, 0), 0, none});
        rows.push_back('{mk_box(-100, 0, -100, 100, 131072, 100, 1), 0, none});
        rows.push_back('{mk_load(0, 65536, 0), 0, none});
        rows.push_back('{mk_box(-300, 0, -100, 300, 131072, 200, 1), 0, none});
        rows.push_back('{mk_load(0, 65536, 0), 0, none});
        rows.push_back('{mk_box(13107, 0, -100, 20000, 131072, 100, 1), 0, none});
        rows.push_back('{mk_box(100000, 0, 100, -100000, 131072, -100, 1), 0, none});
        rows.push_back('{mk_box(5000, 0, 6000, 50000, 131072, 60000, 1), 0, none});
        rows.push_back('{mk_load(0, 65536, 0), 0, none});
        rows.push_back('{mk_box(S32_MIN, S32_MIN, S32_MIN, S32_MAX, S32_MAX, S32_MAX, 1), 1,
                         mk_pos(S32_MAX, 65536, 0, 1)});
        rows.push_back('{mk_load(S32_MAX - 5, 65536, 0), 0, none});
        rows.push_back('{mk_box(S32_MAX - 3000, 0, -50, S32_MAX, 131072, 50, 1), 0, none});
        foreach (rows[i]) send_item(rows[i].it, rows[i].typed, rows[i].want);
        drain_and_settle();

        cfgs = '{'{1, 262144, 1048576, 262144}, '{0, 262144, 1048576, 262144},
                 '{1, 0, 0, 0}, '{1, 13107, 65536, 6554}, '{1, 40000, 98304, 13107}};
        for (int ph = 0; ph < 5; ph++) begin
            if (ph == 4) begin
                cfgs[4][1] = $urandom_range(262143);
                cfgs[4][2] = $urandom_range(2097151);
                cfgs[4][3] = $urandom_range(524287);
            end
            write_reg(cbcr_pkg::REG_ENABLE, cfgs[ph][0]);
            write_reg(cbcr_pkg::REG_RADIUS, cfgs[ph][1]);
            write_reg(cbcr_pkg::REG_EYE, cfgs[ph][2]);
            write_reg(cbcr_pkg::REG_HEAD, cfgs[ph][3]);
            for (int k = 0; k < 246; k++) begin
                case ((k / 41 + ph) % 4)
                    0: begin idle_pct = 0;  stall_pct = 0;  end
                    1: begin idle_pct = 68; stall_pct = 0;  end
                    2: begin idle_pct = 0;  stall_pct = 68; end
                    default: begin idle_pct = 19; stall_pct = 19; end
                endcase
                if (k == 100) begin
                    idle_pct = 0;
                    hold_left = 400;
                end
                send_item(rand_item(), 0, none);
            end
            drain_and_settle();
        end

        // stray high bits of the wide registers
        write_reg(cbcr_pkg::REG_RADIUS, 21'h1FFFFF);
        write_reg(cbcr_pkg::REG_HEAD, 21'h1FFFFF);
        idle_pct = 0; stall_pct = 0;
        for (int k = 0; k < 20; k++) send_item(rand_item(), 0, none);
        drain_and_settle();

        $display("covered directed table, five register settings and %0d checked beats",
                 beats_checked);
        $display("%0d beats moved the player, %0d mismatches", pushes_seen, mismatches);
        if (mismatches == 0) begin
            $display("circle_box_collision_resolver_unit test passed");
        end else begin
            $display("circle_box_collision_resolver_unit test failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/cbcr_pkg.sv
sv/cbcr_cfg_regs.sv
sv/cbcr_shared_unit.sv
sv/circle_box_collision_resolver_unit.sv
dv/tb_top.sv
